// ----- rtl/core/cqd_pkg.sv -----
// cqd_pkg: shared types and constants for the circular queue with dump.
// Request and status codes, the controller command and datapath status structs.
// No dependencies.
package cqd_pkg;

	localparam int REQ_W     = 2;
	localparam int ST_W      = 2;
	localparam int CNT_W     = 5;
	localparam int CFG_W     = 5;
	localparam int CAP_RESET = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_DUMP = 2'd2
	} req_type_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// which kind of result the output register is loaded with
	typedef enum logic [1:0] {
		RES_ENQ   = 2'd0,
		RES_EMPTY = 2'd1,
		RES_DEQ   = 2'd2,
		RES_DUMP  = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     take;     // latch the input word
		logic     enq;      // push latched word
		logic     pop;      // drop front element
		logic     rd_head;  // start a read at the front slot
		logic     rd_next;  // advance the dump walker and read
		logic     load;     // load the output register
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic walk_last;    // dump walker sits on the back slot
		logic out_free;     // output register can take a beat
	} stat_t;

endpackage

// ----- rtl/core/cqd_req_if.sv -----
// cqd_req_if: request channel (valid/ready, request type and data word).
// Depends on cqd_pkg.
interface cqd_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                               valid;
	logic                               ready;
	logic [cqd_pkg::REQ_W-1:0]          req_type;
	logic signed [DATA_WIDTH-1:0]       data_in;

	modport source (output valid, output req_type, output data_in, input ready);
	modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

// ----- rtl/core/cqd_rsp_if.sv -----
// cqd_rsp_if: result channel (valid/ready, status, data, count, last).
// Depends on cqd_pkg.
interface cqd_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                               valid;
	logic                               ready;
	logic [cqd_pkg::ST_W-1:0]           status;
	logic signed [DATA_WIDTH-1:0]       data_out;
	logic [cqd_pkg::CNT_W-1:0]          element_count;
	logic                               last;

	modport source (output valid, output status, output data_out, output element_count,
		output last, input ready);
	modport sink   (input valid, input status, input data_out, input element_count,
		input last, output ready);
endinterface

// ----- rtl/core/circular_queue_with_dump_core.sv -----
// circular_queue_with_dump_core: ring-buffer queue with enqueue, dequeue and dump requests.
// Instantiates cqd_ctrl and cqd_dpath; depends on cqd_pkg, cqd_req_if and cqd_rsp_if.
//
// Ring-buffer FIFO of signed words with a run-time capacity (cfg_wdata, 0 reads as 1,
// values above DEPTH read as DEPTH; reset value 16). Writing the capacity empties the
// queue, so write it only while no request is in flight. Each request beat on req gives
// result beats on rsp: enqueue gives one beat (status ok, or full with the word dropped),
// dequeue gives one beat (ok with the front word, or empty), dump gives one beat per
// stored element front to back with the final beat flagged last and carrying the count,
// or a single empty beat. Unused request codes are taken and give nothing. An enqueue,
// empty dequeue or empty dump is answered from the execute state; a dequeue or dump
// first reads the front slot through the registered read port of the storage array,
// then emits; a dump streams one beat per cycle while the result sink takes them.
// One request is worked on at a time. A finished beat waits in the output register,
// and the next request is accepted while it waits. The storage needs no clearing
// after reset: only written slots are ever read.
module circular_queue_with_dump_core #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cqd_pkg::CFG_W-1:0] cfg_wdata,
	cqd_req_if.sink                   req,
	cqd_rsp_if.source                 rsp
);
	import cqd_pkg::*;

	// command/status pair between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: accepts request beats, steps enqueue/dequeue/dump
	cqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage, pointers, dump walker and result register
	cqd_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.data_in   (req.data_in),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/cqd_ctrl.sv -----
// cqd_ctrl: request sequencer for the circular queue.
// Drives cqd_pkg::cmd_t to the datapath from its cqd_pkg::stat_t; depends on cqd_pkg.
module cqd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [cqd_pkg::REQ_W-1:0] req_type,
	output logic                      req_ready,
	input  cqd_pkg::stat_t            stat,
	output cqd_pkg::cmd_t             cmd
);
	import cqd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EMIT
	} state_t;

	state_t    state_q, state_d;
	req_type_t req_q;

	always_comb begin
		cmd         = '0;
		cmd.res_sel = RES_ENQ;
		state_d     = state_q;
		req_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					// unused code: beat is swallowed, nothing happens
					if (req_type inside {REQ_ENQ, REQ_DEQ, REQ_DUMP}) begin
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				case (req_q)
					REQ_ENQ: begin
						if (stat.out_free) begin
							cmd.enq     = 1'b1;
							cmd.load    = 1'b1;
							cmd.res_sel = RES_ENQ;
							state_d     = S_IDLE;
						end
					end
					default: begin
						// dequeue or dump
						if (stat.empty) begin
							if (stat.out_free) begin
								cmd.load    = 1'b1;
								cmd.res_sel = RES_EMPTY;
								state_d     = S_IDLE;
							end
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = S_EMIT;
						end
					end
				endcase
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					if (req_q == REQ_DEQ) begin
						cmd.res_sel = RES_DEQ;
						cmd.pop     = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.res_sel = RES_DUMP;
						if (stat.walk_last) begin
							state_d = S_IDLE;
						end else begin
							cmd.rd_next = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= REQ_ENQ;
		end else begin
			state_q <= state_d;
			if (cmd.take) begin
				req_q <= req_type_t'(req_type);
			end
		end
	end

endmodule

// ----- rtl/core/cqd_dpath.sv -----
// cqd_dpath: ring storage, head/tail/empty tracking, dump walker and result register.
// Commanded by cqd_ctrl through cqd_pkg::cmd_t; depends on cqd_pkg and cqd_rsp_if.
module cqd_dpath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cqd_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic signed [DATA_WIDTH-1:0] data_in,
	input  cqd_pkg::cmd_t                cmd,
	output cqd_pkg::stat_t               stat,
	cqd_rsp_if.source                    rsp
);
	import cqd_pkg::*;

	localparam int IW      = $clog2(DEPTH);
	localparam int CW      = IW + 1;
	localparam int CAP_RST = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [IW-1:0]         capm1_q;  // highest slot index in use
	logic [IW-1:0]         head_q, tail_q, ptr_q;
	logic                  empty_q;
	logic [DATA_WIDTH-1:0] din_q, rdata_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  out_last_q;

	logic [IW-1:0]         tail_nx, head_nx, ptr_nx, cfg_capm1;
	logic [CW-1:0]         count_w;
	logic                  full;

	assign tail_nx = (tail_q == capm1_q) ? '0 : tail_q + 1'b1;
	assign head_nx = (head_q == capm1_q) ? '0 : head_q + 1'b1;
	assign ptr_nx  = (ptr_q == capm1_q) ? '0 : ptr_q + 1'b1;
	assign full    = !empty_q && (tail_nx == head_q);

	// stored elements; zero-based slot distance plus one, wrapped by capacity
	always_comb begin
		if (tail_q >= head_q) begin
			count_w = {1'b0, tail_q} - {1'b0, head_q} + 1'b1;
		end else begin
			count_w = {1'b0, tail_q} + {1'b0, capm1_q} + CW'(2) - {1'b0, head_q};
		end
	end

	// capacity written as 0 acts as 1, above DEPTH acts as DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_capm1 = '0;
		end else if (int'(cfg_wdata) > DEPTH) begin
			cfg_capm1 = IW'(DEPTH - 1);
		end else begin
			cfg_capm1 = IW'(cfg_wdata - 1'b1);
		end
	end

	assign stat.empty     = empty_q;
	assign stat.walk_last = (ptr_q == tail_q);
	assign stat.out_free  = !out_valid_q || rsp.ready;

	// queue pointers and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capm1_q <= IW'(CAP_RST - 1);
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cfg_we) begin
			capm1_q <= cfg_capm1;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.enq) begin
			if (empty_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b0;
			end else if (!full) begin
				tail_q <= tail_nx;
			end
		end else if (cmd.pop) begin
			if (head_q == tail_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else begin
				head_q <= head_nx;
			end
		end
	end

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.enq && !full) begin
			mem[empty_q ? '0 : tail_nx] <= din_q;
		end
		if (cmd.rd_head) begin
			rdata_q <= mem[head_q];
		end else if (cmd.rd_next) begin
			rdata_q <= mem[ptr_nx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			din_q <= data_in;
		end
		if (cmd.rd_head) begin
			ptr_q <= head_q;
		end else if (cmd.rd_next) begin
			ptr_q <= ptr_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.res_sel)
				RES_ENQ: begin
					out_status_q <= full ? ST_FULL : ST_OK;
					out_data_q   <= '0;
					out_count_q  <= '0;
					out_last_q   <= 1'b1;
				end
				RES_EMPTY: begin
					out_status_q <= ST_EMPTY;
					out_data_q   <= '0;
					out_count_q  <= '0;
					out_last_q   <= 1'b1;
				end
				RES_DEQ: begin
					out_status_q <= ST_OK;
					out_data_q   <= rdata_q;
					out_count_q  <= '0;
					out_last_q   <= 1'b1;
				end
				default: begin
					out_status_q <= ST_OK;
					out_data_q   <= rdata_q;
					out_count_q  <= stat.walk_last ? CNT_W'(count_w) : '0;
					out_last_q   <= stat.walk_last;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.data_out      = out_data_q;
	assign rsp.element_count = out_count_q;
	assign rsp.last          = out_last_q;

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.enq && cmd.pop))
		else $error("push and pop commanded together");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> stat.out_free)
		else $error("result loaded over an untaken beat");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> !stat.walk_last)
		else $error("dump walker stepped past the back slot");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop && (head_q == tail_q) |=> empty_q)
		else $error("taking the only element left the queue non-empty");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq && !cfg_we |=> !empty_q)
		else $error("queue empty after a push");

endmodule

// ----- test/circular_queue_with_dump_checker.sv -----
`timescale 1ns / 100ps
// Checker for circular_queue_with_dump_core: watches request and result beats,
// predicts the result stream of the ring queue and compares it field by field.
// Depends on cqd_pkg.
module circular_queue_with_dump_checker #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cqd_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  logic [cqd_pkg::REQ_W-1:0]    req_type,
	input  logic signed [DATA_WIDTH-1:0] data_in,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  logic [cqd_pkg::ST_W-1:0]     status,
	input  logic signed [DATA_WIDTH-1:0] data_out,
	input  logic [cqd_pkg::CNT_W-1:0]    element_count,
	input  logic                         last,
	output int                           mismatches,
	output int                           outstanding
);
	import cqd_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]             status;
		logic signed [DATA_WIDTH-1:0] data;
		logic [CNT_W-1:0]            count;
		logic                        last;
	} queue_beat_t;

	// predicted queue state
	logic signed [DATA_WIDTH-1:0] ring [DEPTH];
	int                           head;
	int                           tail;
	bit                           empty;
	logic [CFG_W-1:0]             capacity;

	queue_beat_t expected_beats [$];
	queue_beat_t want;
	int          beat_no;
	int          errors = 0;

	assign mismatches = errors;

	// capacity register as the block uses it: 0 -> 1, above DEPTH -> DEPTH
	function automatic int usable_slots();
		if (capacity == 0)
			return 1;
		if (capacity > DEPTH)
			return DEPTH;
		return capacity;
	endfunction

	function automatic int ring_next(input int i, input int cap);
		return (i + 1 >= cap) ? 0 : i + 1;
	endfunction

	task automatic queue_result(input logic [ST_W-1:0] st, input logic signed [DATA_WIDTH-1:0] d,
		input int cnt, input bit fin);
		queue_beat_t b;
		b.status = st;
		b.data   = d;
		b.count  = cnt[CNT_W-1:0];
		b.last   = fin;
		expected_beats.push_back(b);
	endtask

	task automatic predict_request(input logic [REQ_W-1:0] kind,
		input logic signed [DATA_WIDTH-1:0] word);
		int cap;
		int n;
		int i;
		int k;
		cap = usable_slots();
		if (head >= cap)
			head = 0;
		if (tail >= cap)
			tail = 0;
		case (kind)
			REQ_ENQ: begin
				if (empty) begin
					head    = 0;
					tail    = 0;
					ring[0] = word;
					empty   = 1'b0;
					queue_result(ST_OK, '0, 0, 1'b1);
				end else if (ring_next(tail, cap) == head) begin
					queue_result(ST_FULL, '0, 0, 1'b1);
				end else begin
					tail       = ring_next(tail, cap);
					ring[tail] = word;
					queue_result(ST_OK, '0, 0, 1'b1);
				end
			end
			REQ_DEQ: begin
				if (empty) begin
					queue_result(ST_EMPTY, '0, 0, 1'b1);
				end else begin
					queue_result(ST_OK, ring[head], 0, 1'b1);
					if (head == tail) begin
						head  = 0;
						tail  = 0;
						empty = 1'b1;
					end else begin
						head = ring_next(head, cap);
					end
				end
			end
			REQ_DUMP: begin
				if (empty) begin
					queue_result(ST_EMPTY, '0, 0, 1'b1);
				end else begin
					n = (tail >= head) ? tail - head + 1 : tail + cap - head + 1;
					i = head;
					for (k = 0; k < n; k++) begin
						queue_result(ST_OK, ring[i], (k == n - 1) ? n : 0, k == n - 1);
						i = ring_next(i, cap);
					end
				end
			end
			default: ; // unused code: taken, no result
		endcase
	endtask

	task automatic report_mismatch(input string what, input longint exp_val, input longint got_val);
		errors++;
		$display("cqd check: beat %0d %s: expected %0d, got %0d",
			beat_no, what, exp_val, got_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head     = 0;
			tail     = 0;
			empty    = 1'b1;
			capacity = CFG_W'(CAP_RESET);
			expected_beats.delete();
			beat_no  = 0;
			outstanding <= 0;
		end else begin
			// results first: a beat at this edge belongs to an earlier request
			if (rsp_valid && rsp_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat, data", 0, data_out);
				end else begin
					want = expected_beats.pop_front();
					if (status !== want.status)
						report_mismatch("status", want.status, status);
					if (data_out !== want.data)
						report_mismatch("data_out", want.data, data_out);
					if (element_count !== want.count)
						report_mismatch("element_count", want.count, element_count);
					if (last !== want.last)
						report_mismatch("last", want.last, last);
				end
				beat_no++;
			end
			if (cfg_we) begin
				capacity = cfg_wdata;
				head     = 0;
				tail     = 0;
				empty    = 1'b1;
			end
			if (req_valid && req_ready)
				predict_request(req_type, data_in);
			outstanding <= expected_beats.size();
		end
	end

endmodule

// ----- test/circular_queue_with_dump_core_test.sv -----
`timescale 1ns / 100ps
// Top of the circular_queue_with_dump_core bench: clock, reset, stimulus and verdict.
// Depends on cqd_pkg, cqd_req_if, cqd_rsp_if, the core and circular_queue_with_dump_checker.
module circular_queue_with_dump_core_test;
	import cqd_pkg::*;

	localparam int DEPTH        = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int DRAIN_CYCLES = 20;    // covers the worst request latency with margin
	localparam int HOLD_CYCLES  = 200;   // long result-side hold-off
	localparam int IDLE_LIMIT   = 3000;  // cycles without any beat before giving up
	localparam int PHASE_ITEMS  = 39;
	localparam int NUM_PHASES   = 10;

	// the one request code the block takes and ignores
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	int mismatches;
	int outstanding;

	// receiver controls, set by the stimulus process
	bit hold_rx = 1'b0;  // request one long hold-off
	bit no_gaps = 1'b0;  // stretch with both sides running flat out

	cqd_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
	cqd_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_if ();

	circular_queue_with_dump_core #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	circular_queue_with_dump_checker #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) queue_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_if.valid),
		.req_ready    (req_if.ready),
		.req_type     (req_if.req_type),
		.data_in      (req_if.data_in),
		.rsp_valid    (rsp_if.valid),
		.rsp_ready    (rsp_if.ready),
		.status       (rsp_if.status),
		.data_out     (rsp_if.data_out),
		.element_count(rsp_if.element_count),
		.last         (rsp_if.last),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length for either side: mostly none, often a few cycles, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Data words lean on the extremes of the signed range.
	function automatic logic signed [DATA_WIDTH-1:0] random_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// enq_weight out of 85 splits enqueue against dequeue; dumps about 12%,
	// the ignored code about 3%.
	function automatic logic [REQ_W-1:0] random_kind(input int enq_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return REQ_UNUSED;
		if (r < 15)
			return REQ_DUMP;
		return ($urandom_range(0, 84) < enq_weight) ? REQ_ENQ : REQ_DEQ;
	endfunction

	// Offer one request beat; returns at the edge that accepts it, valid still high.
	task automatic send_req(input logic [REQ_W-1:0] kind, input logic signed [DATA_WIDTH-1:0] word);
		req_if.valid    <= 1'b1;
		req_if.req_type <= kind;
		req_if.data_in  <= word;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	// Optional idle cycles after an accepted beat. With no gap, valid stays high
	// and the next send_req just updates the payload.
	task automatic sender_gap();
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted beat has arrived, then let the
	// block settle (an ignored request may still be in the sequencer).
	// The checker's count is registered, hence the first edge before looking.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Only called right after wait_drained, so the block is idle.
	task automatic write_capacity(input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Result side: random ready with runs and gaps, plus one long hold-off on request.
	initial begin
		int run;
		int gap;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				run = no_gaps ? 50 : $urandom_range(1, 12);
				gap = pick_gap();
				rsp_if.ready <= 1'b1;
				repeat (run) @(posedge clk);
				if (gap != 0) begin
					rsp_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus
	initial begin
		int               phase_caps [NUM_PHASES];
		int               p;
		int               counted;
		int               enq_weight;
		logic [REQ_W-1:0] kind;

		req_if.valid    = 1'b0;
		req_if.req_type = REQ_ENQ;
		req_if.data_in  = '0;
		// low and high extremes, out-of-range values both ways, and small rings
		// that wrap often; one random size in the middle
		phase_caps = '{16, 2, 3, 31, 1, 8, 17, 0, 5, 4};
		phase_caps[8] = $urandom_range(1, 16);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, capacity at its reset value ---
		// empty dequeue and empty dump
		send_req(REQ_DEQ, '1);          sender_gap();
		send_req(REQ_DUMP, '0);         sender_gap();
		// signed extremes go in, get dumped and come back out in order
		send_req(REQ_ENQ, 32'h7fff_ffff); sender_gap();
		send_req(REQ_ENQ, 32'h8000_0000); sender_gap();
		send_req(REQ_ENQ, '0);          sender_gap();
		send_req(REQ_ENQ, '1);          sender_gap();
		send_req(REQ_DUMP, 32'h5a5a_5a5a); sender_gap();
		// ignored code must not disturb anything
		send_req(REQ_UNUSED, 32'h1234_5678); sender_gap();
		send_req(REQ_DEQ, '0);          sender_gap();
		send_req(REQ_DUMP, '0);         sender_gap();
		send_req(REQ_DEQ, '0);          sender_gap();
		send_req(REQ_DEQ, '0);          sender_gap();
		// taking the last element empties the queue
		send_req(REQ_DEQ, '0);          sender_gap();
		send_req(REQ_DEQ, '0);          sender_gap();
		send_req(REQ_DUMP, '0);

		// one-slot ring: second enqueue reports full
		wait_drained();
		write_capacity(5'd1);
		send_req(REQ_ENQ, 32'h1234_5678); sender_gap();
		send_req(REQ_ENQ, 32'h0bad_f00d); sender_gap();
		send_req(REQ_DUMP, '0);         sender_gap();
		send_req(REQ_DEQ, '0);          sender_gap();
		send_req(REQ_DEQ, '0);

		// capacity 0 behaves as 1; leave a word behind so the next write empties it
		wait_drained();
		write_capacity(5'd0);
		send_req(REQ_ENQ, 32'hcafe_0001); sender_gap();
		send_req(REQ_ENQ, 32'hcafe_0002); sender_gap();
		send_req(REQ_DUMP, '0);

		// --- random phases, one capacity each ---
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_capacity(phase_caps[p][CFG_W-1:0]);
			no_gaps = (p == 5);
			// first phase: result side stalls long while requests keep coming
			if (p == 0)
				hold_rx = 1'b1;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				// alternate fill and drain waves so the ring fills, wraps and empties; phases 2, 5 and 8 use a balanced mix
				if (p % 3 == 2)
					enq_weight = 44;
				else
					enq_weight = ((counted / 12) % 2 == 0) ? 62 : 26;
				kind = random_kind(enq_weight);
				send_req(kind, random_word());
				if (kind != REQ_UNUSED)
					counted++;
				// sender now and then waits for the result stream to catch up
				if ((p == 1 && counted == 20) || $urandom_range(0, 99) == 0)
					wait_drained();
				else
					sender_gap();
			end
			no_gaps = 1'b0;
		end

		wait_drained();
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
